[rtl/msmf_pkg.sv]
// ----------------------------------------------------------------------------
// msmf_pkg
// Types, status byte codes and the message length lookup for the MIDI
// stream message framer.
// ----------------------------------------------------------------------------
package msmf_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte0;
      logic [6:0] out_byte1;
      logic [6:0] out_byte2;
      logic [1:0] out_count;
      logic       is_sysex;
      logic       sysex_end;
   } rsp_payload_type;

   localparam logic [7:0] SYSEX_START    = 8'hF0;
   localparam logic [7:0] SYS_MTC        = 8'hF1;
   localparam logic [7:0] SYS_SONG_POS   = 8'hF2;
   localparam logic [7:0] SYS_SONG_SEL   = 8'hF3;
   localparam logic [7:0] SYS_UNDEF_F4   = 8'hF4;
   localparam logic [7:0] SYS_UNDEF_F5   = 8'hF5;
   localparam logic [7:0] SYSEX_END      = 8'hF7;
   localparam logic [7:0] REALTIME_FIRST = 8'hF8;
   localparam logic [7:0] NO_STATUS      = 8'h00;

   localparam logic [1:0] LEN_ONE   = 2'd1;
   localparam logic [1:0] LEN_TWO   = 2'd2;
   localparam logic [1:0] LEN_THREE = 2'd3;

   // full message length of a status byte
   function automatic logic [1:0] msg_length(input logic [7:0] status);
      logic [1:0] len;
      len = LEN_ONE;
      if (status < SYSEX_START) begin
         if (status[7:5] == 3'b110) begin
            len = LEN_TWO;
         end else begin
            len = LEN_THREE;
         end
      end else if (status == SYS_MTC || status == SYS_SONG_SEL) begin
         len = LEN_TWO;
      end else if (status == SYS_SONG_POS) begin
         len = LEN_THREE;
      end
      return len;
   endfunction

endpackage

[rtl/msmf_stream_if.sv]
// ----------------------------------------------------------------------------
// msmf_stream_if
// Valid/ready stream channel carrying one payload struct per request.
// ----------------------------------------------------------------------------
interface msmf_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/midi_stream_message_framer_top.sv]
// ----------------------------------------------------------------------------
// midi_stream_message_framer_top
// Frames a raw MIDI byte stream into whole messages with running status,
// sysex pass-through and real-time bytes passed out at once.
// ----------------------------------------------------------------------------
// One byte is accepted per request on req, every cycle while req.ready is
// high, and at most one message leaves on rsp for it, from the output
// register. The parser state is updated in the accepting cycle by a
// single pass of logic; the result goes to an output register backed by a
// one-entry skid register, so req.ready drops only while both are full, that
// is after rsp stalled with a result waiting and a new one arrived.
module midi_stream_message_framer_top (
   input  logic                 clock,
   input  logic                 reset,
   msmf_stream_if.sink          req,
   msmf_stream_if.source        rsp
);

   logic [7:0]                 held_status_ff, held_status_in;
   logic                       in_sysex_ff, in_sysex_in;
   logic [6:0]                 first_data_ff, first_data_in;
   logic [1:0]                 gathered_ff, gathered_in;
   logic [1:0]                 needed_ff, needed_in;

   logic                       out_valid_ff, out_valid_in;
   msmf_pkg::rsp_payload_type  out_data_ff, out_data_in;
   logic                       skid_valid_ff, skid_valid_in;
   msmf_pkg::rsp_payload_type  skid_data_ff, skid_data_in;

   logic                       accept;
   logic                       pop;
   logic                       emit;
   logic                       push;
   logic                       handled;
   logic [7:0]                 b;
   logic [1:0]                 len;
   logic [1:0]                 gath;
   msmf_pkg::rsp_payload_type  res;

   assign b       = req.payload.in_byte;
   assign accept  = req.valid && req.ready;
   assign pop     = out_valid_ff && rsp.ready;
   assign push    = accept && emit;
   assign len     = msmf_pkg::msg_length(b);

   // byte parser
   always_comb begin
      held_status_in = held_status_ff;
      in_sysex_in    = in_sysex_ff;
      first_data_in  = first_data_ff;
      gathered_in    = gathered_ff;
      needed_in      = needed_ff;
      emit           = 1'b0;
      handled        = 1'b0;
      gath           = gathered_ff;
      res            = '{out_byte0: b, out_byte1: 7'd0, out_byte2: 7'd0,
                         out_count: msmf_pkg::LEN_ONE, is_sysex: 1'b0,
                         sysex_end: 1'b0};
      if (b >= msmf_pkg::REALTIME_FIRST) begin
         emit = 1'b1;
      end else begin
         if (in_sysex_ff) begin
            if (!b[7]) begin
               emit         = 1'b1;
               res.is_sysex = 1'b1;
               handled      = 1'b1;
            end else begin
               in_sysex_in = 1'b0;
               if (b == msmf_pkg::SYSEX_END) begin
                  emit          = 1'b1;
                  res.is_sysex  = 1'b1;
                  res.sysex_end = 1'b1;
                  handled       = 1'b1;
               end
            end
         end
         if (!handled) begin
            if (b[7]) begin
               if (b == msmf_pkg::SYS_UNDEF_F4 || b == msmf_pkg::SYS_UNDEF_F5) begin
                  emit = 1'b0;
               end else if (b == msmf_pkg::SYSEX_START) begin
                  in_sysex_in    = 1'b1;
                  held_status_in = msmf_pkg::NO_STATUS;
                  gathered_in    = 2'd0;
                  needed_in      = 2'd0;
                  emit           = 1'b1;
                  res.is_sysex   = 1'b1;
               end else if (len == msmf_pkg::LEN_ONE) begin
                  held_status_in = msmf_pkg::NO_STATUS;
                  gathered_in    = 2'd0;
                  needed_in      = 2'd0;
                  emit           = 1'b1;
               end else begin
                  held_status_in = b;
                  gathered_in    = 2'd1;
                  needed_in      = len;
               end
            end else if (held_status_ff != msmf_pkg::NO_STATUS) begin
               // running status restarts a complete message
               if (gathered_ff >= needed_ff) begin
                  gath = 2'd1;
               end
               res.out_byte0 = held_status_ff;
               if (gath == 2'd1) begin
                  first_data_in = b[6:0];
                  gathered_in   = 2'd2;
                  if (needed_ff == msmf_pkg::LEN_TWO) begin
                     emit          = 1'b1;
                     res.out_byte1 = b[6:0];
                     res.out_count = msmf_pkg::LEN_TWO;
                  end
               end else begin
                  gathered_in   = 2'd3;
                  emit          = 1'b1;
                  res.out_byte1 = first_data_ff;
                  res.out_byte2 = b[6:0];
                  res.out_count = msmf_pkg::LEN_THREE;
               end
               // system common clears running status once complete
               if (emit && held_status_ff >= msmf_pkg::SYSEX_START) begin
                  held_status_in = msmf_pkg::NO_STATUS;
                  gathered_in    = 2'd0;
                  needed_in      = 2'd0;
               end
            end
         end
      end
   end

   // output register with skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = push;
            skid_data_in  = res;
         end else begin
            out_valid_in = push;
            out_data_in  = res;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_status_ff <= msmf_pkg::NO_STATUS;
         in_sysex_ff    <= 1'b0;
         gathered_ff    <= 2'd0;
         needed_ff      <= 2'd0;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            held_status_ff <= held_status_in;
            in_sysex_ff    <= in_sysex_in;
            gathered_ff    <= gathered_in;
            needed_ff      <= needed_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         first_data_ff <= first_data_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req.ready   = !skid_valid_ff;
   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_data_ff;

   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without output entry");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_data_ff.out_count != 2'd0))
      else $error("result with zero byte count");

   a_sysex_single: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.is_sysex) |-> (out_data_ff.out_count == msmf_pkg::LEN_ONE))
      else $error("sysex result with more than one byte");

   a_end_is_sysex: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.sysex_end) |-> out_data_ff.is_sysex)
      else $error("sysex end flag outside sysex result");

   a_sysex_no_status: assert property (@(posedge clock) disable iff (reset)
      in_sysex_ff |-> (held_status_ff == msmf_pkg::NO_STATUS))
      else $error("running status held inside sysex");

   a_gathered_bound: assert property (@(posedge clock) disable iff (reset)
      gathered_ff <= needed_ff)
      else $error("more bytes gathered than the message needs");

endmodule
